// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/core/tswdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tswdt_pkg
// Types and constants of the two-stage watchdog timeout block.
// ----------------------------------------------------------------------------
package tswdt_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      SEL_RELOAD  = 3'd0,
      SEL_INITIAL = 3'd1,
      SEL_STATUS1 = 3'd2,
      SEL_STATUS2 = 3'd3,
      SEL_CONTROL = 3'd4,
      SEL_NOREBOOT = 3'd5
   } sel_type;

   typedef enum logic {
      CSR_TCO_VERSION = 1'b0,
      CSR_NR_LOCKED   = 1'b1
   } csr_type;

   localparam logic [15:0] HALT_BIT      = 16'h0800;
   localparam logic [15:0] TO_STS_BIT    = 16'h0008;
   localparam logic [15:0] SECOND_TO_BIT = 16'h0002;
   localparam logic [15:0] NR_BIT_V2     = 16'h0020;
   localparam logic [15:0] NR_BIT_V1     = 16'h0002;
   localparam logic [15:0] MIN_INITIAL   = 16'h0004;
   localparam logic [15:0] V1_MASK       = 16'h003f;
   localparam logic [15:0] V2_MASK       = 16'h03ff;
   localparam logic [15:0] LOW_BYTE      = 16'h00ff;
   localparam logic [15:0] INITIAL_RESET = 16'h0004;
   localparam logic [1:0]  VERSION_V1    = 2'd1;
   localparam logic [1:0]  VERSION_RESET = 2'd2;

   typedef struct packed {
      logic [15:0] read_data;
      logic        reboot_request;
      logic        first_expiry;
   } result_type;

endpackage

// ===== rtl/core/tswdt_core.sv =====
// ----------------------------------------------------------------------------
// tswdt_core
// Watchdog state, configuration registers and the per-item update.
// ----------------------------------------------------------------------------
module tswdt_core
   import tswdt_pkg::*;
#(
   parameter int COUNT_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [1:0]        mode,
   input  logic [2:0]        reg_sel,
   input  logic [15:0]       write_data,
   input  logic              csr_write_en,
   input  logic [0:0]        csr_index,
   input  logic [1:0]        csr_wdata,
   output result_type        result
);

   localparam logic [15:0] CountMask = 16'((32'd1 << COUNT_BITS) - 32'd1);

   logic [1:0]            version_ff, version_in;
   logic                  locked_ff, locked_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [15:0]           initial_ff, initial_in;
   logic                  timeout_ff, timeout_in;
   logic                  second_ff, second_in;
   logic [15:0]           control_ff, control_in;
   logic                  noreboot_ff, noreboot_in;

   logic                  is_v1;
   logic [15:0]           timer_mask;
   logic [15:0]           nr_pos;
   logic [COUNT_BITS-1:0] reload_value;
   logic [COUNT_BITS-1:0] count_dec;

   assign is_v1        = (version_ff == VERSION_V1);
   assign timer_mask   = is_v1 ? V1_MASK : (V2_MASK & CountMask);
   assign nr_pos       = is_v1 ? NR_BIT_V1 : NR_BIT_V2;
   assign reload_value = COUNT_BITS'(initial_ff & timer_mask & CountMask);
   assign count_dec    = count_ff - COUNT_BITS'(1);

   always_comb begin
      version_in  = version_ff;
      locked_in   = locked_ff;
      count_in    = count_ff;
      initial_in  = initial_ff;
      timeout_in  = timeout_ff;
      second_in   = second_ff;
      control_in  = control_ff;
      noreboot_in = noreboot_ff;
      result      = '0;

      if (csr_write_en) begin
         unique case (csr_type'(csr_index))
            CSR_TCO_VERSION: version_in = csr_wdata;
            CSR_NR_LOCKED:   locked_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (fire) begin
         unique case (mode_type'(mode))
            MODE_TICK: begin
               if ((control_ff & HALT_BIT) == '0) begin
                  count_in = count_dec;
                  if (count_dec == '0) begin
                     count_in = reload_value;
                     if (!timeout_ff) begin
                        timeout_in          = 1'b1;
                        result.first_expiry = 1'b1;
                     end else begin
                        second_in             = 1'b1;
                        result.reboot_request = !noreboot_ff;
                     end
                  end
               end
            end
            MODE_WRITE: begin
               unique case (sel_type'(reg_sel))
                  SEL_RELOAD: count_in = reload_value;
                  SEL_INITIAL: begin
                     if ((write_data & timer_mask) >= MIN_INITIAL) begin
                        initial_in = is_v1 ? (write_data & LOW_BYTE) : write_data;
                     end
                  end
                  SEL_STATUS1: begin
                     if ((write_data & TO_STS_BIT) != '0) timeout_in = 1'b0;
                  end
                  SEL_STATUS2: begin
                     if ((write_data & SECOND_TO_BIT) != '0) second_in = 1'b0;
                  end
                  SEL_CONTROL: control_in = write_data;
                  SEL_NOREBOOT: begin
                     if ((write_data & nr_pos) != '0) begin
                        noreboot_in = 1'b1;
                     end else if (!locked_ff) begin
                        noreboot_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_READ: begin
               unique case (sel_type'(reg_sel))
                  SEL_RELOAD:   result.read_data = 16'(count_ff) & timer_mask;
                  SEL_INITIAL:  result.read_data = is_v1 ? (initial_ff & LOW_BYTE)
                                                         : initial_ff;
                  SEL_STATUS1:  result.read_data = timeout_ff ? TO_STS_BIT : '0;
                  SEL_STATUS2:  result.read_data = second_ff ? SECOND_TO_BIT : '0;
                  SEL_CONTROL:  result.read_data = control_ff;
                  SEL_NOREBOOT: result.read_data = noreboot_ff ? nr_pos : '0;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff  <= VERSION_RESET;
         locked_ff   <= 1'b0;
         count_ff    <= COUNT_BITS'(4);
         initial_ff  <= INITIAL_RESET;
         timeout_ff  <= 1'b0;
         second_ff   <= 1'b0;
         control_ff  <= HALT_BIT;
         noreboot_ff <= 1'b1;
      end else begin
         version_ff  <= version_in;
         locked_ff   <= locked_in;
         count_ff    <= count_in;
         initial_ff  <= initial_in;
         timeout_ff  <= timeout_in;
         second_ff   <= second_in;
         control_ff  <= control_in;
         noreboot_ff <= noreboot_in;
      end
   end

endmodule

// ===== rtl/core/watchdog_two_stage_timeout.sv =====
// ----------------------------------------------------------------------------
// watchdog_two_stage_timeout
// Two-stage countdown watchdog with a byte-style register file.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | mode, reg_sel, write_data
//   rsp     | out       | rsp_valid/rsp_stall  | read_data, reboot_request,
//           |           |                      | first_expiry
//   csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// One item per cycle while rsp_stall is low. An accepted item waits in
// the input register; when it fires, the state update and the result
// register take it together and rsp_valid rises.
// Synchronous reset clears both stages and loads the register reset values.
// A stalled result holds; the input register still takes one more item,
// then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module watchdog_two_stage_timeout
   import tswdt_pkg::*;
#(
   parameter int COUNT_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_reg_sel,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_reboot_request,
   output logic        rsp_first_expiry,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [1:0]  csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  mode_ff;
   logic [2:0]  sel_ff;
   logic [15:0] data_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  result_ff;
   result_type  result;
   logic        out_free;
   logic        fire;
   logic        req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (in_valid_ff && !fire);
   assign out_valid_in = fire ? 1'b1 : (out_valid_ff && rsp_stall);

   tswdt_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .mode         (mode_ff),
      .reg_sel      (sel_ff),
      .write_data   (data_ff),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         sel_ff  <= req_reg_sel;
         data_ff <= req_write_data;
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = result_ff.read_data;
   assign rsp_reboot_request = result_ff.reboot_request;
   assign rsp_first_expiry   = result_ff.first_expiry;

endmodule

// ===== rtl/core/tswdt_checker.sv =====
// ----------------------------------------------------------------------------
// tswdt_checker
// Port-level checks of the watchdog result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tswdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_read_data,
   input logic        rsp_reboot_request,
   input logic        rsp_first_expiry
);

   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_valid_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_CLK(a_one_expiry_kind, clock, reset, rsp_valid |-> !(rsp_reboot_request && rsp_first_expiry))
   `ASSERT_CLK(a_tick_reads_zero, clock, reset, rsp_valid && (rsp_reboot_request || rsp_first_expiry) |-> rsp_read_data == 16'h0000)

endmodule

bind watchdog_two_stage_timeout tswdt_checker u_tswdt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_read_data      (rsp_read_data),
   .rsp_reboot_request (rsp_reboot_request),
   .rsp_first_expiry   (rsp_first_expiry)
);

// ===== sim/watchdog_two_stage_timeout_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// watchdog_two_stage_timeout_tb
// Self-checking bench for the two-stage watchdog timeout block.
//
// Register accesses and timer ticks go in on the request channel. A
// scoreboard keeps its own copy of the counter, the status bits and the
// control registers, works out the response of every accepted item, and
// checks each response in order. The run covers a short directed sequence
// through both timeout stages and then random traffic under several
// generation and lock settings. The sender idles in bursts, the receiver
// stalls on its own pattern, and once it holds off long enough to back up
// the block.
// ----------------------------------------------------------------------------
module watchdog_two_stage_timeout_tb;
   import tswdt_pkg::*;

   localparam int          COUNT_BITS     = 10;
   localparam logic [15:0] COUNT_MASK     = 16'((32'd1 << COUNT_BITS) - 32'd1);
   localparam logic [1:0]  MODE_NONE      = 2'd3;
   localparam logic [2:0]  SEL_UNUSED_LO  = 3'd6;
   localparam logic [2:0]  SEL_UNUSED_HI  = 3'd7;
   localparam int          PHASE_ITEMS    = 200;
   localparam int          HOLD_CYCLES    = 120;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          PRINT_LIMIT    = 100;

   class timeout_scoreboard;
      logic [1:0]            version;
      logic                  locked;
      logic [COUNT_BITS-1:0] count;
      logic [15:0]           initial_word;
      logic                  timed_out;
      logic                  second_out;
      logic [15:0]           control;
      logic                  nr_flag;
      result_type            expected_responses[$];
      int                    mismatches;

      function new();
         version      = VERSION_RESET;
         locked       = 1'b0;
         count        = COUNT_BITS'(INITIAL_RESET);
         initial_word = INITIAL_RESET;
         timed_out    = 1'b0;
         second_out   = 1'b0;
         control      = HALT_BIT;
         nr_flag      = 1'b1;
         mismatches   = 0;
      endfunction

      function void set_csr(csr_type index, logic [1:0] value);
         if (index == CSR_TCO_VERSION) begin
            version = value;
         end else begin
            locked = value[0];
         end
      endfunction

      function logic [15:0] timer_mask();
         return (version == VERSION_V1) ? V1_MASK : (V2_MASK & COUNT_MASK);
      endfunction

      function logic [15:0] noreboot_bit();
         return (version == VERSION_V1) ? NR_BIT_V1 : NR_BIT_V2;
      endfunction

      function void reload_count();
         count = COUNT_BITS'(initial_word & timer_mask());
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function void note_access(logic [1:0] mode, logic [2:0] sel, logic [15:0] data);
         result_type rsp;
         rsp = '0;
         case (mode)
            MODE_TICK: begin
               if ((control & HALT_BIT) == '0) begin
                  count = count - 1'b1;
                  if (count == '0) begin
                     reload_count();
                     if (!timed_out) begin
                        timed_out = 1'b1;
                        rsp.first_expiry = 1'b1;
                     end else begin
                        second_out = 1'b1;
                        rsp.reboot_request = !nr_flag;
                     end
                  end
               end
            end
            MODE_WRITE: begin
               case (sel)
                  SEL_RELOAD: reload_count();
                  SEL_INITIAL: begin
                     if ((data & timer_mask()) >= MIN_INITIAL)
                        initial_word = (version == VERSION_V1) ? (data & LOW_BYTE) : data;
                  end
                  SEL_STATUS1: if ((data & TO_STS_BIT) != '0) timed_out = 1'b0;
                  SEL_STATUS2: if ((data & SECOND_TO_BIT) != '0) second_out = 1'b0;
                  SEL_CONTROL: control = data;
                  SEL_NOREBOOT: begin
                     if ((data & noreboot_bit()) != '0) begin
                        nr_flag = 1'b1;
                     end else if (!locked) begin
                        nr_flag = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_READ: begin
               case (sel)
                  SEL_RELOAD:   rsp.read_data = 16'(count) & timer_mask();
                  SEL_INITIAL:  rsp.read_data = (version == VERSION_V1) ?
                                                (initial_word & LOW_BYTE) : initial_word;
                  SEL_STATUS1:  rsp.read_data = timed_out ? TO_STS_BIT : '0;
                  SEL_STATUS2:  rsp.read_data = second_out ? SECOND_TO_BIT : '0;
                  SEL_CONTROL:  rsp.read_data = control;
                  SEL_NOREBOOT: rsp.read_data = nr_flag ? noreboot_bit() : '0;
                  default: ;
               endcase
            end
            default: ;
         endcase
         expected_responses.push_back(rsp);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_response(logic [15:0] read_data, logic reboot, logic first);
         result_type exp;
         if (expected_responses.size() == 0) begin
            report_mismatch("response with no item outstanding");
         end else begin
            exp = expected_responses.pop_front();
            if (read_data !== exp.read_data)
               report_mismatch($sformatf("read_data %h, expected %h",
                                         read_data, exp.read_data));
            if (reboot !== exp.reboot_request)
               report_mismatch($sformatf("reboot_request %b, expected %b",
                                         reboot, exp.reboot_request));
            if (first !== exp.first_expiry)
               report_mismatch($sformatf("first_expiry %b, expected %b",
                                         first, exp.first_expiry));
         end
      endtask
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode       = MODE_TICK;
   logic [2:0]  req_reg_sel    = SEL_RELOAD;
   logic [15:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [15:0] rsp_read_data;
   logic        rsp_reboot_request;
   logic        rsp_first_expiry;
   logic        csr_write_en   = 1'b0;
   logic [0:0]  csr_index      = CSR_TCO_VERSION;
   logic [1:0]  csr_wdata      = '0;

   logic        hold_armed     = 1'b0;
   int          idle_cycles    = 0;
   timeout_scoreboard sb      = new();

   always #5 clock = ~clock;

   watchdog_two_stage_timeout #(
      .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_reg_sel        (req_reg_sel),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_first_expiry   (rsp_first_expiry),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_access(req_mode, req_reg_sel, req_write_data);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_read_data, rsp_reboot_request, rsp_first_expiry);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall patterns, plus one long hold-off on request
   initial begin : rsp_stall_gen
      int pattern;
      int left;
      int n;
      pattern = 0;
      left    = 0;
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            if (left == 0) begin
               pattern = $urandom_range(0, 3);
               left    = $urandom_range(20, 120);
            end
            left--;
            case (pattern)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic send(logic [1:0] mode, logic [2:0] sel, logic [15:0] data);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_reg_sel    <= sel;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // drop valid and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] version, logic locked);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_TCO_VERSION;
      csr_wdata    <= version;
      @(posedge clock);
      sb.set_csr(CSR_TCO_VERSION, version);
      csr_index    <= CSR_NR_LOCKED;
      csr_wdata    <= {1'($urandom_range(0, 1)), locked};
      @(posedge clock);
      sb.set_csr(CSR_NR_LOCKED, {1'b0, locked});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void random_access(output logic [1:0] mode, output logic [2:0] sel,
                                         output logic [15:0] data);
      int r;
      r    = $urandom_range(0, 99);
      data = 16'($urandom_range(0, 16'hffff));
      sel  = 3'($urandom_range(0, 7));
      mode = MODE_WRITE;
      if (r < 55) begin
         mode = MODE_TICK;
      end else if (r < 58) begin
         sel = SEL_RELOAD;
      end else if (r < 63) begin
         sel = SEL_INITIAL;
         if ($urandom_range(0, 3) != 0) data = 16'($urandom_range(0, 12));
      end else if (r < 68) begin
         sel = SEL_STATUS1;
      end else if (r < 72) begin
         sel = SEL_STATUS2;
      end else if (r < 76) begin
         sel = SEL_CONTROL;
         if ($urandom_range(0, 5) != 0) data = data & ~HALT_BIT;
      end else if (r < 80) begin
         sel = SEL_NOREBOOT;
      end else if (r < 82) begin
         sel = 3'($urandom_range(SEL_UNUSED_LO, SEL_UNUSED_HI));
      end else if (r < 96) begin
         mode = MODE_READ;
      end else begin
         mode = MODE_NONE;
      end
   endfunction

   task automatic directed();
      int n;
      // reset contents
      send(MODE_READ, SEL_RELOAD, '0);
      send(MODE_READ, SEL_INITIAL, '0);
      send(MODE_READ, SEL_STATUS1, '0);
      send(MODE_READ, SEL_CONTROL, '0);
      send(MODE_READ, SEL_NOREBOOT, '0);
      send(MODE_READ, SEL_UNUSED_HI, 16'hffff);
      // halted tick, rejected and extreme initial values
      send(MODE_TICK, SEL_RELOAD, '0);
      send(MODE_WRITE, SEL_INITIAL, 16'h0003);
      send(MODE_WRITE, SEL_INITIAL, 16'hffff);
      send(MODE_WRITE, SEL_INITIAL, MIN_INITIAL);
      send(MODE_WRITE, SEL_CONTROL, '0);
      send(MODE_WRITE, SEL_NOREBOOT, '0);
      send(MODE_WRITE, SEL_RELOAD, 16'hffff);
      // first expiry, then second expiry with reboot
      for (n = 0; n < 8; n++) send(MODE_TICK, SEL_RELOAD, '0);
      send(MODE_READ, SEL_STATUS1, '0);
      send(MODE_READ, SEL_STATUS2, '0);
      send(MODE_WRITE, SEL_STATUS1, TO_STS_BIT);
      send(MODE_WRITE, SEL_STATUS2, SECOND_TO_BIT);
      send(MODE_NONE, SEL_UNUSED_LO, 16'hffff);
   endtask

   task automatic random_phase(int phase);
      int          sent;
      int          burst;
      logic [1:0]  mode;
      logic [2:0]  sel;
      logic [15:0] data;
      send(MODE_WRITE, SEL_CONTROL, 16'($urandom_range(0, 16'hffff)) & ~HALT_BIT);
      send(MODE_WRITE, SEL_INITIAL, 16'($urandom_range(4, 12)));
      send(MODE_WRITE, SEL_RELOAD, '0);
      sent = 3;
      while (sent < PHASE_ITEMS) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < PHASE_ITEMS) begin
            random_access(mode, sel, data);
            send(mode, sel, data);
            sent++;
            burst--;
            if (sent == PHASE_ITEMS / 2) begin
               if (phase == 1) hold_armed = 1'b1;
               if (phase == 3) begin
                  req_valid <= 1'b0;
                  do @(posedge clock); while (sb.pending() != 0);
               end
            end
         end
         if ($urandom_range(0, 9) >= 3) pause($urandom_range(1, 8));
      end
   endtask

   initial begin : stimulus
      logic [1:0] versions[6];
      logic       locks[6];
      int         p;
      versions = '{VERSION_RESET, VERSION_V1, 2'd3, 2'd0, VERSION_V1, VERSION_RESET};
      locks    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      configure(VERSION_RESET, 1'b0);
      directed();
      drain();
      for (p = 0; p < 6; p++) begin
         configure(versions[p], locks[p]);
         random_phase(p);
         drain();
      end
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tswdt_pkg.sv
rtl/core/tswdt_core.sv
rtl/core/watchdog_two_stage_timeout.sv
rtl/core/tswdt_checker.sv
sim/watchdog_two_stage_timeout_tb.sv
